// ----- src/ordered_array_insert_delete_engine_core_macros.svh -----
// Assertion macros used by the checker of the packed list engine.
// The enclosing scope must provide clk and rst_n.
`ifndef ORDERED_ARRAY_INSERT_DELETE_ENGINE_CORE_MACROS_SVH
`define ORDERED_ARRAY_INSERT_DELETE_ENGINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLIE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olie: check failed");

// Consequent must hold in the cycle after the antecedent.
`define OLIE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olie: check failed");

`endif

// ----- src/olie_pkg.sv -----
package olie_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_EDIT   = 3'd2,
    FN_DELETE = 3'd3,
    FN_GET    = 3'd4,
    FN_FIND   = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Write request into the word store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

endpackage

// ----- src/olie_in_if.sv -----
interface olie_in_if import olie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink (input valid, input func, input position, input value, output ready);
endinterface

// ----- src/olie_out_if.sv -----
interface olie_out_if import olie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_value;
  logic                     found;
  logic [FPOS_W-1:0]        found_position;
  logic [CNT_W-1:0]         item_count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output read_value, output found,
                  output found_position, output item_count, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input status, input read_value, input found,
                input found_position, input item_count, input is_empty,
                input is_full, output ready);
endinterface

// ----- src/olie_store.sv -----
module olie_store import olie_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/ordered_array_insert_delete_engine_core.sv -----
// Packed list engine: one transaction at a time, ready only while idle.
// Shifts and searches move one entry per cycle; ready returns the cycle after the result
// is taken.
// Reset (rst_n, synchronous, active low) clears the count and state; store words are not.
module ordered_array_insert_delete_engine_core import olie_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  olie_in_if.sink    in_chan,
  olie_out_if.source out_chan
);

  // The sequencer walks the store one entry per cycle. Every walking state
  // sees the word read in the previous cycle on rd_data and issues the next
  // read, so a shift writes one entry per cycle while reading its neighbor.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_INS,
    S_DN,
    S_FIND,
    S_GET,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  status_t                  status_r, status_nxt;
  logic [DATA_W-1:0]        rd_r, rd_nxt;
  logic                     found_r, found_nxt;
  logic [FPOS_W-1:0]        fpos_r, fpos_nxt;

  store_wr_t                store_wr;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DATA_W-1:0]        rd_data;

  logic                     accept;
  logic [ADDR_W-1:0]        last_addr;
  logic                     match;

  olie_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept    = in_chan.valid && (state_r == S_IDLE);
  // Address of the highest live entry; only used while the store is not empty.
  assign last_addr = ADDR_W'(count_r - CNT_W'(1));
  // The one shared word comparator, used by find.
  assign match     = (rd_data == val_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    found_nxt  = found_r;
    fpos_nxt   = fpos_r;
    store_wr   = '{en: 1'b0, addr: idx_r, data: rd_data};
    rd_addr    = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt    = in_chan.position;
          val_nxt    = in_chan.value;
          status_nxt = ST_OK;
          rd_nxt     = '0;
          found_nxt  = 1'b0;
          fpos_nxt   = '0;
          state_nxt  = S_DONE;
          case (in_chan.func) inside
            FN_APPEND: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                store_wr  = '{en: 1'b1, addr: ADDR_W'(count_r), data: in_chan.value};
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FN_INSERT: begin
              // The index is checked before fullness.
              if (in_chan.position > count_r) begin
                status_nxt = ST_BAD_INDEX;
              end else if (count_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (in_chan.position == count_r) begin
                store_wr  = '{en: 1'b1, addr: in_chan.position[ADDR_W-1:0],
                              data: in_chan.value};
                count_nxt = count_r + CNT_W'(1);
              end else begin
                // Move entries up starting from the tail.
                rd_addr   = last_addr;
                idx_nxt   = last_addr;
                state_nxt = S_UP;
              end
            end
            FN_EDIT, FN_DELETE, FN_GET: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (in_chan.position >= count_r) begin
                status_nxt = ST_BAD_INDEX;
              end else if (in_chan.func == FN_EDIT) begin
                store_wr = '{en: 1'b1, addr: in_chan.position[ADDR_W-1:0],
                             data: in_chan.value};
              end else if (in_chan.func == FN_DELETE) begin
                if (in_chan.position[ADDR_W-1:0] == last_addr) begin
                  count_nxt = count_r - CNT_W'(1);
                end else begin
                  rd_addr   = in_chan.position[ADDR_W-1:0] + ADDR_W'(1);
                  idx_nxt   = in_chan.position[ADDR_W-1:0] + ADDR_W'(1);
                  state_nxt = S_DN;
                end
              end else begin
                rd_addr   = in_chan.position[ADDR_W-1:0];
                state_nxt = S_GET;
              end
            end
            FN_FIND: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            default: begin
              // Unused selectors give an ok result and leave the store alone.
            end
          endcase
          if (status_nxt != ST_OK) begin
            rd_nxt = '1;
          end
        end
      end

      S_UP: begin
        // Word of entry idx_r is on rd_data; it moves one place up.
        store_wr = '{en: 1'b1, addr: idx_r + ADDR_W'(1), data: rd_data};
        if (POS_W'(idx_r) == pos_r) begin
          state_nxt = S_INS;
        end else begin
          rd_addr = idx_r - ADDR_W'(1);
          idx_nxt = idx_r - ADDR_W'(1);
        end
      end

      S_INS: begin
        store_wr  = '{en: 1'b1, addr: pos_r[ADDR_W-1:0], data: val_r};
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DN: begin
        // Word of entry idx_r is on rd_data; it moves one place down.
        store_wr = '{en: 1'b1, addr: idx_r - ADDR_W'(1), data: rd_data};
        if (idx_r == last_addr) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          rd_addr = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      S_FIND: begin
        if (match) begin
          found_nxt = 1'b1;
          fpos_nxt  = FPOS_W'(idx_r);
          state_nxt = S_DONE;
        end else if (idx_r == last_addr) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      S_GET: begin
        rd_nxt    = rd_data;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
  end

  // The count only changes on the way into the result state, so the count
  // flags can be taken straight from the live count register.
  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = (state_r == S_DONE);
  assign out_chan.status         = status_r;
  assign out_chan.read_value     = rd_r;
  assign out_chan.found          = found_r;
  assign out_chan.found_position = fpos_r;
  assign out_chan.item_count     = count_r;
  assign out_chan.is_empty       = (count_r == '0);
  assign out_chan.is_full        = (count_r == CNT_W'(DEPTH));

endmodule

// ----- src/olie_checker.sv -----
`include "ordered_array_insert_delete_engine_core_macros.svh"

module olie_checker import olie_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [DATA_W-1:0] out_read_value,
  input logic              out_found,
  input logic [CNT_W-1:0]  out_item_count
);

  // One transaction in flight: no new request is taken while a result waits.
  `OLIE_ASSERT_IMPLY(a_no_accept_while_result, out_valid, !in_ready)

  // Every failed request reports the error word.
  `OLIE_ASSERT_IMPLY(a_error_word, out_valid && (out_status != ST_OK), out_read_value == '1)

  // A hit is only reported with an ok status on a non-empty list.
  `OLIE_ASSERT_IMPLY(a_found_ok, out_valid && out_found,
                     (out_status == ST_OK) && (out_item_count != '0))

  // The live count never exceeds the capacity while a result is offered.
  `OLIE_ASSERT_IMPLY(a_count_range, out_valid, out_item_count <= CNT_W'(DEPTH))

  // A stalled result stays offered.
  `OLIE_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

endmodule

bind ordered_array_insert_delete_engine_core olie_checker u_olie_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_read_value (out_chan.read_value),
  .out_found      (out_chan.found),
  .out_item_count (out_chan.item_count)
);
